// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define C3RB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence checked in the cycle after the trigger.
`define C3RB_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/c3rb_pkg.sv -----
// Package for the 3x3 replicate-border convolution: sizes, codes, types and helpers.
package c3rb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 24;
    localparam int CFG_DIM_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int VAL_W     = 20;
    localparam int POS_W     = 10;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SLOTS  = 3;
    localparam int WORD_W = SLOTS * PIX_W;

    // output queue, power of two
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_DIM_W-1:0] DIM_RESET = CFG_DIM_W'(1024);

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COEFF0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    typedef logic [1:0] slot_t;
    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [WORD_W-1:0] word_t;
    // window [a][b]: a = 0 right, 1 centre, 2 left column; b = 0 lower, 1 centre, 2 upper row
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;
    typedef logic [2:0][CFG_W-1:0] coeffs_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
    } pos_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        pos_t                    pos;
    } res_t;

    typedef struct packed {
        logic valid;
        win_t win;
        pos_t pos;
    } mac_in_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } mac_out_t;

    function automatic logic [DIM_W-1:0] clamp_w(input logic [CFG_DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > MAX_WIDTH)
            r = DIM_W'(MAX_WIDTH);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_h(input logic [CFG_DIM_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v == '0)
            r = ROW_W'(1);
        else if (v > MAX_HEIGHT)
            r = ROW_W'(MAX_HEIGHT);
        else
            r = ROW_W'(v);
        return r;
    endfunction

    function automatic slot_t slot_inc(input slot_t s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic slot_t slot_dec(input slot_t s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic pix_t lane_pick(input word_t w, input slot_t s);
        pix_t r;
        case (s)
            2'd0:    r = w[PIX_W-1:0];
            2'd1:    r = w[2*PIX_W-1:PIX_W];
            2'd2:    r = w[3*PIX_W-1:2*PIX_W];
            default: r = w[PIX_W-1:0];
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/c3rb_ifs.sv -----
// Handshake interfaces for the pixel, result and configuration channels.
interface c3rb_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [c3rb_pkg::PIX_W-1:0] pixel;

    modport source (output valid, action, pixel, input ready);
    modport sink   (input valid, action, pixel, output ready);
endinterface

interface c3rb_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [c3rb_pkg::VAL_W-1:0] value;
    logic [c3rb_pkg::POS_W-1:0]        out_x;
    logic [c3rb_pkg::POS_W-1:0]        out_y;
    logic                             last;

    modport source (output valid, value, out_x, out_y, last, input ready);
    modport sink   (input valid, value, out_x, out_y, last, output ready);
endinterface

interface c3rb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [c3rb_pkg::CFG_IDX_W-1:0] index;
    logic [c3rb_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/c3rb_line_mem.sv -----
// Three-row line memory: one column word per address, byte-lane write, two read ports.
module c3rb_line_mem (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [c3rb_pkg::COL_W-1:0]   wr_addr,
    input  c3rb_pkg::slot_t              wr_lane,
    input  c3rb_pkg::pix_t               wr_data,
    input  logic                         rd_en,
    input  logic [c3rb_pkg::COL_W-1:0]   rd_addr_a,
    input  logic [c3rb_pkg::COL_W-1:0]   rd_addr_b,
    output c3rb_pkg::word_t              rd_data_a,
    output c3rb_pkg::word_t              rd_data_b
);

    c3rb_pkg::word_t mem [c3rb_pkg::MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_lane)
                2'd0:    mem[wr_addr][0 +: c3rb_pkg::PIX_W] <= wr_data;
                2'd1:    mem[wr_addr][c3rb_pkg::PIX_W +: c3rb_pkg::PIX_W] <= wr_data;
                2'd2:    mem[wr_addr][2*c3rb_pkg::PIX_W +: c3rb_pkg::PIX_W] <= wr_data;
                default: ;
            endcase
        end
    end

    // read-before-write on a clash; the caller forwards the new pixel
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- hw/rtl/c3rb_mac.sv -----
// Nine-tap multiply and add tree, three register stages.
module c3rb_mac (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c3rb_pkg::coeffs_t    coeffs,
    input  c3rb_pkg::mac_in_t    din,
    output c3rb_pkg::mac_out_t   dout
);

    localparam int PROD_W = 2 * c3rb_pkg::PIX_W + 1;
    localparam int RSUM_W = PROD_W + 2;

    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [RSUM_W-1:0] rsum_next [3];
    logic signed [RSUM_W-1:0] rsum_reg  [3];
    logic signed [c3rb_pkg::VAL_W-1:0] total_next;
    logic signed [c3rb_pkg::VAL_W-1:0] total_reg;

    logic v1_reg, v2_reg, v3_reg;
    c3rb_pkg::pos_t pos1_reg, pos2_reg, pos3_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                prod_next[a][b] =
                    PROD_W'($signed(coeffs[a][c3rb_pkg::PIX_W*b +: c3rb_pkg::PIX_W])) *
                    PROD_W'($signed({1'b0, din.win[a][b]}));
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            rsum_next[a] = RSUM_W'(prod_reg[a][0]) + RSUM_W'(prod_reg[a][1])
                         + RSUM_W'(prod_reg[a][2]);
        end
        total_next = c3rb_pkg::VAL_W'(rsum_reg[0]) + c3rb_pkg::VAL_W'(rsum_reg[1])
                   + c3rb_pkg::VAL_W'(rsum_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= din.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid)
        begin
            prod_reg <= prod_next;
            pos1_reg <= din.pos;
        end
        if (v1_reg)
        begin
            rsum_reg <= rsum_next;
            pos2_reg <= pos1_reg;
        end
        if (v2_reg)
        begin
            total_reg <= total_next;
            pos3_reg  <= pos2_reg;
        end
    end

    assign dout.valid     = v3_reg;
    assign dout.res.value = total_reg;
    assign dout.res.pos   = pos3_reg;

endmodule

// ----- hw/rtl/conv3x3_replicate_border.sv -----
// Top level of the streaming 3x3 convolution with replicated image border.
// Pixels enter in raster order on the pixel channel, one beat per clock; each beat either
// brings a pixel (action 0) or asks for one pending output (action 1, used after the last
// pixel of the frame to drain what is left). A beat yields at most one result, in raster
// order, with the convolution value, its column and row, and last set on the frame's final
// output. Sustained rate is one beat per clock: the line memory gives the two columns an
// output needs (centre and right) through its two read ports in one access, and the left
// column comes from the previous output's read. Each result then passes window assembly,
// the multiply-add tree and the output queue. The input holds off only while eight results
// are outstanding (in the pipeline or in the output queue), so a stalled consumer
// throttles the source without losing beats. Frame dimensions are sampled at the first beat
// of a frame; the coefficients and dimensions must only be written while the block is idle.
// The line memory (MAX_WIDTH words of three pixels) needs no clearing after reset.
`include "assert_macros.svh"

module conv3x3_replicate_border (
    input  logic          clk,
    input  logic          rst_n,
    c3rb_pix_if.sink      pixels,
    c3rb_res_if.source    results,
    c3rb_cfg_if.sink      cfg
);

    localparam int COL_W = c3rb_pkg::COL_W;
    localparam int DIM_W = c3rb_pkg::DIM_W;
    localparam int ROW_W = c3rb_pkg::ROW_W;

    // ---------------- configuration registers ----------------
    c3rb_pkg::coeffs_t                  coeffs_reg;
    logic [c3rb_pkg::CFG_DIM_W-1:0]     img_w_reg;
    logic [c3rb_pkg::CFG_DIM_W-1:0]     img_h_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg <= '0;
            img_w_reg  <= c3rb_pkg::DIM_RESET;
            img_h_reg  <= c3rb_pkg::DIM_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                c3rb_pkg::REG_COEFF0: coeffs_reg[0] <= cfg.data;
                c3rb_pkg::REG_COEFF1: coeffs_reg[1] <= cfg.data;
                c3rb_pkg::REG_COEFF2: coeffs_reg[2] <= cfg.data;
                c3rb_pkg::REG_WIDTH:  img_w_reg <= cfg.data[c3rb_pkg::CFG_DIM_W-1:0];
                c3rb_pkg::REG_HEIGHT: img_h_reg <= cfg.data[c3rb_pkg::CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- position state ----------------
    // in_*: next pixel to arrive; em_*: next output to emit. Slots track row mod 3.
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    c3rb_pkg::slot_t   in_slot_reg, in_slot_next;
    logic [COL_W-1:0]  em_col_reg, em_col_next;
    logic [ROW_W-1:0]  em_row_reg, em_row_next;
    c3rb_pkg::slot_t   em_slot_reg, em_slot_next;
    logic [DIM_W-1:0]  fw_reg, fw_next;
    logic [ROW_W-1:0]  fh_reg, fh_next;

    // outstanding results: in the pipeline plus in the output queue
    logic [c3rb_pkg::OCC_W-1:0] occ_reg, occ_next;

    logic              in_acc, is_pix, at_start, rx_done;
    logic [DIM_W-1:0]  eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [DIM_W-1:0]  col_inc, ex1;
    logic              row_wrap, em_wrap, ey_more, frame_end;
    logic [COL_W-1:0]  nc, nx, ptr_c;
    logic [ROW_W-1:0]  nr, ey1, ny, ry0, ptr_r;
    c3rb_pkg::slot_t   ns;
    logic              out_rdy, take_pix, do_emit, res_pop;
    c3rb_pkg::slot_t   slot_sel [3];
    logic [2:0]        fwd_c, fwd_r;

    assign in_acc   = pixels.valid && pixels.ready;
    assign is_pix   = (pixels.action == c3rb_pkg::ACT_PIXEL);
    assign at_start = (in_col_reg == '0) && (in_row_reg == '0)
                   && (em_col_reg == '0) && (em_row_reg == '0);

    // dimensions in force for this beat: fresh from the registers at frame start
    assign eff_w   = at_start ? c3rb_pkg::clamp_w(img_w_reg) : fw_reg;
    assign eff_h   = at_start ? c3rb_pkg::clamp_h(img_h_reg) : fh_reg;
    assign rx_done = (in_row_reg >= eff_h);

    // input pointer after this pixel
    assign col_inc  = DIM_W'(in_col_reg) + DIM_W'(1);
    assign row_wrap = (col_inc >= eff_w);
    assign nc       = row_wrap ? '0 : COL_W'(col_inc);
    assign nr       = row_wrap ? in_row_reg + ROW_W'(1) : in_row_reg;
    assign ns       = row_wrap ? c3rb_pkg::slot_inc(in_slot_reg) : in_slot_reg;

    // lower-right neighbour of the pending output, clamped into the frame
    assign ex1     = DIM_W'(em_col_reg) + DIM_W'(1);
    assign em_wrap = (ex1 >= eff_w);
    assign nx      = em_wrap ? COL_W'(eff_w - DIM_W'(1)) : COL_W'(ex1);
    assign ey1     = em_row_reg + ROW_W'(1);
    assign ey_more = (ey1 < eff_h);
    assign ny      = ey_more ? ey1 : eff_h - ROW_W'(1);
    assign ry0     = (em_row_reg == '0) ? em_row_reg : em_row_reg - ROW_W'(1);
    assign frame_end = em_wrap && !ey_more;

    // a pixel beat counts its own pixel as arrived
    assign ptr_c   = is_pix ? nc : in_col_reg;
    assign ptr_r   = is_pix ? nr : in_row_reg;
    assign out_rdy = (ny < ptr_r) || ((ny == ptr_r) && (nx < ptr_c));

    // pixels after the frame's last one are dropped
    assign take_pix = in_acc && is_pix && !rx_done;
    assign do_emit  = in_acc && out_rdy && (!is_pix || !rx_done);

    // memory slot of each window row: lower, centre, upper
    assign slot_sel[0] = ey_more ? c3rb_pkg::slot_inc(em_slot_reg) : em_slot_reg;
    assign slot_sel[1] = em_slot_reg;
    assign slot_sel[2] = (em_row_reg == '0) ? em_slot_reg : c3rb_pkg::slot_dec(em_slot_reg);

    // the incoming pixel is not in memory yet on this beat's read: forward it
    always_comb
    begin
        logic [2:0] row_hit;
        row_hit[0] = (in_row_reg == ny);
        row_hit[1] = (in_row_reg == em_row_reg);
        row_hit[2] = (in_row_reg == ry0);
        for (int b = 0; b < 3; b++)
        begin
            fwd_c[b] = is_pix && row_hit[b] && (in_col_reg == em_col_reg);
            fwd_r[b] = is_pix && row_hit[b] && (in_col_reg == nx);
        end
    end

    assign res_pop = results.valid && results.ready;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_slot_next = in_slot_reg;
        em_col_next  = em_col_reg;
        em_row_next  = em_row_reg;
        em_slot_next = em_slot_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        if (in_acc && at_start)
        begin
            fw_next = eff_w;
            fh_next = eff_h;
        end
        if (take_pix)
        begin
            in_col_next  = nc;
            in_row_next  = nr;
            in_slot_next = ns;
        end
        if (do_emit)
        begin
            if (em_wrap)
            begin
                em_col_next  = '0;
                em_row_next  = ey1;
                em_slot_next = c3rb_pkg::slot_inc(em_slot_reg);
            end
            else
            begin
                em_col_next = COL_W'(ex1);
            end
            // final output: wait for a new frame
            if (frame_end)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                in_slot_next = '0;
                em_col_next  = '0;
                em_row_next  = '0;
                em_slot_next = '0;
            end
        end
        occ_next = occ_reg + c3rb_pkg::OCC_W'(do_emit) - c3rb_pkg::OCC_W'(res_pop);
    end

    assign pixels.ready = (occ_reg < c3rb_pkg::OCC_W'(c3rb_pkg::FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_slot_reg <= '0;
            em_col_reg  <= '0;
            em_row_reg  <= '0;
            em_slot_reg <= '0;
            fw_reg      <= c3rb_pkg::clamp_w(c3rb_pkg::DIM_RESET);
            fh_reg      <= c3rb_pkg::clamp_h(c3rb_pkg::DIM_RESET);
            occ_reg     <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_slot_reg <= in_slot_next;
            em_col_reg  <= em_col_next;
            em_row_reg  <= em_row_next;
            em_slot_reg <= em_slot_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            occ_reg     <= occ_next;
        end
    end

    // ---------------- line memory ----------------
    // read centre and right columns of the output; write the arriving pixel
    c3rb_pkg::word_t rd_a, rd_b;

    c3rb_line_mem u_line_mem (
        .clk       (clk),
        .wr_en     (take_pix),
        .wr_addr   (in_col_reg),
        .wr_lane   (in_slot_reg),
        .wr_data   (pixels.pixel),
        .rd_en     (do_emit),
        .rd_addr_a (em_col_reg),
        .rd_addr_b (nx),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // ---------------- stage 1: beat info alongside the memory read ----------------
    logic            s1_valid_reg;
    c3rb_pkg::pos_t  s1_pos_reg;
    logic            s1_first_reg;
    c3rb_pkg::slot_t s1_slot_reg [3];
    logic [2:0]      s1_fwd_c_reg, s1_fwd_r_reg;
    c3rb_pkg::pix_t  s1_px_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= do_emit;
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            s1_pos_reg.x    <= c3rb_pkg::POS_W'(em_col_reg);
            s1_pos_reg.y    <= c3rb_pkg::POS_W'(em_row_reg);
            s1_pos_reg.last <= frame_end;
            s1_first_reg    <= (em_col_reg == '0);
            s1_slot_reg     <= slot_sel;
            s1_fwd_c_reg    <= fwd_c;
            s1_fwd_r_reg    <= fwd_r;
            s1_px_reg       <= pixels.pixel;
        end
    end

    // ---------------- stage 2: window assembly ----------------
    // left column is the previous output's centre column, or the centre itself at x = 0
    c3rb_pkg::pix_t  centre [3];
    c3rb_pkg::pix_t  left_reg [3];
    c3rb_pkg::win_t  win_next, s2_win_reg;
    logic            s2_valid_reg;
    c3rb_pkg::pos_t  s2_pos_reg;

    always_comb
    begin
        for (int b = 0; b < 3; b++)
        begin
            centre[b] = s1_fwd_c_reg[b] ? s1_px_reg
                                        : c3rb_pkg::lane_pick(rd_a, s1_slot_reg[b]);
            win_next[0][b] = s1_fwd_r_reg[b] ? s1_px_reg
                                             : c3rb_pkg::lane_pick(rd_b, s1_slot_reg[b]);
            win_next[1][b] = centre[b];
            win_next[2][b] = s1_first_reg ? centre[b] : left_reg[b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_win_reg <= win_next;
            s2_pos_reg <= s1_pos_reg;
            left_reg   <= centre;
        end
    end

    // ---------------- stages 3 to 5: multiply and sum ----------------
    c3rb_pkg::mac_in_t  mac_in;
    c3rb_pkg::mac_out_t mac_out;

    assign mac_in.valid = s2_valid_reg;
    assign mac_in.win   = s2_win_reg;
    assign mac_in.pos   = s2_pos_reg;

    c3rb_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .coeffs (coeffs_reg),
        .din    (mac_in),
        .dout   (mac_out)
    );

    // ---------------- output queue ----------------
    // sized to the outstanding limit, so a push never finds it full
    c3rb_pkg::res_t                 fifo_mem [c3rb_pkg::FIFO_DEPTH];
    logic [c3rb_pkg::FIFO_AW-1:0]   head_reg, tail_reg;
    logic [c3rb_pkg::OCC_W-1:0]     fifo_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (mac_out.valid)
                tail_reg <= tail_reg + c3rb_pkg::FIFO_AW'(1);
            if (res_pop)
                head_reg <= head_reg + c3rb_pkg::FIFO_AW'(1);
            fifo_cnt_reg <= fifo_cnt_reg + c3rb_pkg::OCC_W'(mac_out.valid)
                          - c3rb_pkg::OCC_W'(res_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_out.valid)
            fifo_mem[tail_reg] <= mac_out.res;
    end

    assign results.valid = (fifo_cnt_reg != '0);
    assign results.value = fifo_mem[head_reg].value;
    assign results.out_x = fifo_mem[head_reg].pos.x;
    assign results.out_y = fifo_mem[head_reg].pos.y;
    assign results.last  = fifo_mem[head_reg].pos.last;

    // ---------------- checks ----------------
    `C3RB_ASSERT(a_occ_bound, occ_reg <= c3rb_pkg::OCC_W'(c3rb_pkg::FIFO_DEPTH), "outstanding results above queue depth")
    `C3RB_ASSERT(a_queue_in_occ, fifo_cnt_reg <= occ_reg, "queue holds more than outstanding count")
    `C3RB_ASSERT(a_emit_behind, em_row_reg <= in_row_reg, "output row ahead of input row")
    `C3RB_ASSERT_NEXT(a_frame_reset, do_emit && frame_end, (in_col_reg == '0) && (in_row_reg == '0) && (em_col_reg == '0) && (em_row_reg == '0), "positions not cleared after final output")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the streaming 3x3 replicate-border convolution.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // settle gap after the last expected beat, comfortably above the block's latency
    localparam int SETTLE_GAP  = 16;
    // long consumer hold-off, enough for the output queue to fill and stall the input
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BEATS = 120;
    localparam int STEADY_BEATS = 60;

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    c3rb_pix_if pix_bus ();
    c3rb_res_if res_bus ();
    c3rb_cfg_if cfg_bus ();

    conv3x3_replicate_border i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_bus),
        .results (res_bus),
        .cfg     (cfg_bus)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: registers, line store and stream positions
    // ------------------------------------------------------------------
    logic [c3rb_pkg::CFG_W-1:0]     coef_reg [3];
    logic [c3rb_pkg::CFG_DIM_W-1:0] reg_w;
    logic [c3rb_pkg::CFG_DIM_W-1:0] reg_h;
    c3rb_pkg::pix_t                 line_mem [c3rb_pkg::SLOTS][c3rb_pkg::MAX_WIDTH];
    int                   in_col, in_row;     // next pixel to arrive
    int                   emit_col, emit_row; // next output to produce
    int                   frame_w, frame_h;   // dimensions latched for this frame

    c3rb_pkg::res_t pending_outputs [$];

    int n_fail    = 0;
    int beats_used = 0;  // beats the block acted on (ignored pixels not counted)
    bit idle_on   = 1'b1;
    int hold_len  = 0;

    function automatic int dim_clamp(input logic [c3rb_pkg::CFG_DIM_W-1:0] v, input int top);
        if (v == '0)
            return 1;
        if (v > top)
            return top;
        return int'(v);
    endfunction

    function automatic bit at_frame_start();
        return in_col == 0 && in_row == 0 && emit_col == 0 && emit_row == 0;
    endfunction

    // next output can go once its lower-right neighbour (clamped) has arrived
    function automatic bit next_ready(input int pc, input int pr);
        int nx;
        int ny;
        nx = (emit_col + 1 < frame_w) ? emit_col + 1 : frame_w - 1;
        ny = (emit_row + 1 < frame_h) ? emit_row + 1 : frame_h - 1;
        return (ny < pr) || (ny == pr && nx < pc);
    endfunction

    // flipped kernel: k[a][b] weighs the pixel at (x+1-a, y+1-b), clamped into the frame
    function automatic int window_sum(input bit has_new, input c3rb_pkg::pix_t np);
        int acc;
        int tx;
        int ty;
        int cx;
        int cy;
        int kv;
        int pv;
        acc = 0;
        for (int b = 0; b < 3; b++)
        begin
            ty = emit_row + 1 - b;
            cy = (ty < 0) ? 0 : (ty > frame_h - 1) ? frame_h - 1 : ty;
            for (int a = 0; a < 3; a++)
            begin
                tx = emit_col + 1 - a;
                cx = (tx < 0) ? 0 : (tx > frame_w - 1) ? frame_w - 1 : tx;
                kv = int'($signed(coef_reg[a][8*b +: 8]));
                // the pixel arriving in this beat is taken straight from the bus
                pv = (has_new && cx == in_col && cy == in_row) ?
                     int'(np) : int'(line_mem[cy % 3][cx]);
                acc += kv * pv;
            end
        end
        return acc;
    endfunction

    function automatic bit emit_next(input bit has_new, input c3rb_pkg::pix_t np);
        c3rb_pkg::res_t r;
        r.value    = c3rb_pkg::VAL_W'(window_sum(has_new, np));
        r.pos.x    = c3rb_pkg::POS_W'(emit_col);
        r.pos.y    = c3rb_pkg::POS_W'(emit_row);
        r.pos.last = 1'b0;
        emit_col++;
        if (emit_col >= frame_w)
        begin
            emit_col = 0;
            emit_row++;
            if (emit_row >= frame_h)
                r.pos.last = 1'b1;
        end
        pending_outputs.push_back(r);
        return r.pos.last;
    endfunction

    // advance the shadow by one accepted beat; returns 1 when the beat is ignored
    function automatic bit model_beat(input logic act, input c3rb_pkg::pix_t px);
        int nc;
        int nr;
        bit done;
        done = 1'b0;
        if (at_frame_start())
        begin
            frame_w = dim_clamp(reg_w, c3rb_pkg::MAX_WIDTH);
            frame_h = dim_clamp(reg_h, c3rb_pkg::MAX_HEIGHT);
        end
        if (act == c3rb_pkg::ACT_PIXEL)
        begin
            if (in_row >= frame_h)
                return 1'b1;
            nc = in_col + 1;
            nr = in_row;
            if (nc >= frame_w)
            begin
                nc = 0;
                nr++;
            end
            if (next_ready(nc, nr))
                done = emit_next(1'b1, px);
            line_mem[in_row % 3][in_col] = px;
            in_col = nc;
            in_row = nr;
        end
        else if (next_ready(in_col, in_row))
        begin
            done = emit_next(1'b0, '0);
        end
        if (done)
        begin
            in_col   = 0;
            in_row   = 0;
            emit_col = 0;
            emit_row = 0;
        end
        return 1'b0;
    endfunction

    function automatic logic [c3rb_pkg::CFG_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h808080;
            3:       return 24'h7F7F7F;
            default: return c3rb_pkg::CFG_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Reset and the consumer side
    // ------------------------------------------------------------------
    initial
    begin : reset_gen
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Consumer: random short stalls, or one long hold when asked for
    initial
    begin : result_sink
        res_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (hold_len - 1) @(posedge clk);
                hold_len = 0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
            begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // Sampled at the falling edge: valid and ready are settled and the beat
    // is taken at the next rising edge.
    always @(negedge clk)
    begin : result_check
        c3rb_pkg::res_t want;
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected result beat: x=%0d y=%0d value=%0d",
                       res_bus.out_x, res_bus.out_y, res_bus.value);
                n_fail++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (res_bus.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, res_bus.value);
                    n_fail++;
                end
                if (res_bus.out_x !== want.pos.x)
                begin
                    $error("out_x: expected %0d, got %0d", want.pos.x, res_bus.out_x);
                    n_fail++;
                end
                if (res_bus.out_y !== want.pos.y)
                begin
                    $error("out_y: expected %0d, got %0d", want.pos.y, res_bus.out_y);
                    n_fail++;
                end
                if (res_bus.last !== want.pos.last)
                begin
                    $error("last: expected %0d, got %0d", want.pos.last, res_bus.last);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Producer side
    // ------------------------------------------------------------------

    // One pixel-channel beat. Valid stays high on return so back-to-back beats
    // run at full rate; it is lowered only for an idle burst or by settle.
    task automatic send_beat(input logic act, input c3rb_pkg::pix_t px);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix_bus.valid  <= 1'b1;
        pix_bus.action <= act;
        pix_bus.pixel  <= px;
        @(negedge clk);
        while (pix_bus.ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        if (!model_beat(act, px))
            beats_used++;
    endtask

    task automatic write_reg(input logic [c3rb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [c3rb_pkg::CFG_W-1:0]     val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(negedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        case (idx)
            c3rb_pkg::REG_COEFF0: coef_reg[0] = val;
            c3rb_pkg::REG_COEFF1: coef_reg[1] = val;
            c3rb_pkg::REG_COEFF2: coef_reg[2] = val;
            c3rb_pkg::REG_WIDTH:  reg_w = val[c3rb_pkg::CFG_DIM_W-1:0];
            c3rb_pkg::REG_HEIGHT: reg_h = val[c3rb_pkg::CFG_DIM_W-1:0];
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every expected result, then let the pipeline empty out.
    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic write_coeffs(input logic [c3rb_pkg::CFG_W-1:0] g0,
                                input logic [c3rb_pkg::CFG_W-1:0] g1,
                                input logic [c3rb_pkg::CFG_W-1:0] g2);
        write_reg(c3rb_pkg::REG_COEFF0, g0);
        write_reg(c3rb_pkg::REG_COEFF1, g1);
        write_reg(c3rb_pkg::REG_COEFF2, g2);
    endtask

    // One whole frame, ending on the beat that produces last. early_pct mixes
    // drain beats in before the frame is complete, noise_pct mixes stray pixels
    // into the drain. fill >= 0 fixes the pixel value. odd forces one early
    // drain and one stray pixel.
    task automatic run_frame(input int early_pct, input int noise_pct, input int fill,
                             input bit odd);
        bit   started;
        bit   odd_drain;
        bit   odd_pixel;
        c3rb_pkg::pix_t px;
        started   = 1'b0;
        odd_drain = odd;
        odd_pixel = odd;
        while (!started || !at_frame_start())
        begin
            if (fill >= 0)
                px = c3rb_pkg::pix_t'(fill);
            else
                case ($urandom_range(0, 9))
                    0:       px = '0;
                    1:       px = '1;
                    default: px = c3rb_pkg::pix_t'($urandom);
                endcase
            if (started && in_row >= frame_h)
            begin
                // whole frame in: drain, with the odd stray pixel that must be ignored
                if (odd_pixel || $urandom_range(0, 99) < noise_pct)
                begin
                    send_beat(c3rb_pkg::ACT_PIXEL, px);
                    odd_pixel = 1'b0;
                end
                else
                begin
                    send_beat(c3rb_pkg::ACT_DRAIN, px);
                end
            end
            else if (started && (odd_drain || $urandom_range(0, 99) < early_pct))
            begin
                send_beat(c3rb_pkg::ACT_DRAIN, px);
                odd_drain = 1'b0;
            end
            else
            begin
                send_beat(c3rb_pkg::ACT_PIXEL, px);
                started = 1'b1;
            end
        end
    endtask

    // New kernel and small random dimensions, then a few frames.
    task automatic random_phase();
        int w;
        int h;
        int frames;
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = $urandom_range(9, 24);
            default: w = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
            0:       h = 0;
            1:       h = $urandom_range(7, 9);
            default: h = $urandom_range(1, 6);
        endcase
        write_coeffs(pick_coeff(), pick_coeff(), pick_coeff());
        // upper data bits are junk for the dimension registers
        write_reg(c3rb_pkg::REG_WIDTH,  {13'($urandom), 11'(w)});
        write_reg(c3rb_pkg::REG_HEIGHT, {13'($urandom), 11'(h)});
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
        begin
            // now and then a drain at the very start, with nothing to give
            if ($urandom_range(0, 7) == 0)
                send_beat(c3rb_pkg::ACT_DRAIN, c3rb_pkg::pix_t'($urandom));
            run_frame(10, 15, -1, 1'b0);
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Kernel left at its reset value: every output is zero.
    task automatic test_coeff_reset();
        write_reg(c3rb_pkg::REG_WIDTH, 24'd2);
        write_reg(c3rb_pkg::REG_HEIGHT, 24'd2);
        run_frame(0, 0, -1, 1'b0);
        settle();
    endtask

    // Zero dimensions count as one: a 1x1 frame ends on its only pixel.
    task automatic test_single_pixel();
        write_coeffs(24'h7F0180, 24'h01FF7F, 24'h80017F);
        write_reg(c3rb_pkg::REG_WIDTH,  {13'h1FFF, 11'd0});
        write_reg(c3rb_pkg::REG_HEIGHT, {13'h1FFF, 11'd0});
        send_beat(c3rb_pkg::ACT_DRAIN, 8'hFF);   // nothing pending yet
        send_beat(c3rb_pkg::ACT_PIXEL, 8'hFF);
        send_beat(c3rb_pkg::ACT_PIXEL, 8'h00);
        settle();
    endtask

    // Full-scale pixels against the most negative and most positive kernels,
    // with an early drain and a stray pixel during the drain.
    task automatic test_kernel_extremes();
        write_coeffs(24'h808080, 24'h808080, 24'h808080);
        write_reg(c3rb_pkg::REG_WIDTH, 24'd3);
        write_reg(c3rb_pkg::REG_HEIGHT, 24'd2);
        run_frame(0, 0, 255, 1'b1);
        settle();
        write_coeffs(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        run_frame(0, 0, 255, 1'b0);
        settle();
    endtask

    // Width above the maximum clamps to a full 1024-pixel row, one row high.
    task automatic test_wide_row();
        write_coeffs(pick_coeff(), pick_coeff(), pick_coeff());
        write_reg(c3rb_pkg::REG_WIDTH, {13'h0, 11'h7FF});
        write_reg(c3rb_pkg::REG_HEIGHT, 24'd1);
        run_frame(5, 20, -1, 1'b0);
        settle();
    endtask

    // Consumer holds off while pixels keep coming: the input must stall, not drop.
    task automatic test_backpressure();
        write_coeffs(pick_coeff(), pick_coeff(), pick_coeff());
        write_reg(c3rb_pkg::REG_WIDTH, 24'd16);
        write_reg(c3rb_pkg::REG_HEIGHT, 24'd4);
        hold_len = HOLD_CYCLES;
        run_frame(0, 0, -1, 1'b0);
        settle();
    endtask

    task automatic test_random_frames();
        int target;
        target = beats_used + RANDOM_BEATS;
        while (beats_used < target)
            random_phase();
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_steady_stream();
        int target;
        idle_on = 1'b0;
        target  = beats_used + STEADY_BEATS;
        while (beats_used < target)
            random_phase();
    endtask

    initial
    begin : stimulus
        pix_bus.valid  <= 1'b0;
        pix_bus.action <= c3rb_pkg::ACT_PIXEL;
        pix_bus.pixel  <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= c3rb_pkg::REG_COEFF0;
        cfg_bus.data   <= '0;

        // shadow state after reset
        coef_reg[0] = '0;
        coef_reg[1] = '0;
        coef_reg[2] = '0;
        reg_w       = c3rb_pkg::DIM_RESET;
        reg_h       = c3rb_pkg::DIM_RESET;
        in_col      = 0;
        in_row      = 0;
        emit_col    = 0;
        emit_row    = 0;
        frame_w     = c3rb_pkg::MAX_WIDTH;
        frame_h     = c3rb_pkg::MAX_HEIGHT;
        for (int s = 0; s < c3rb_pkg::SLOTS; s++)
            for (int c = 0; c < c3rb_pkg::MAX_WIDTH; c++)
                line_mem[s][c] = '0;

        @(posedge rst_n);
        @(posedge clk);

        test_coeff_reset();
        test_single_pixel();
        test_kernel_extremes();
        test_wide_row();
        test_backpressure();
        test_random_frames();
        test_steady_stream();

        settle();
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial
    begin : watchdog
        #400us;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/c3rb_pkg.sv
hw/rtl/c3rb_ifs.sv
hw/rtl/c3rb_line_mem.sv
hw/rtl/c3rb_mac.sv
hw/rtl/conv3x3_replicate_border.sv
tb/sv/testbench.sv
